### sv/lcps_pkg.sv
package lcps_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int CENT_W     = 9;
   localparam int SPEED_W    = 8;
   localparam int STEER_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ERR_W      = 10;
   localparam int DERR_W     = 11;
   localparam int PPROD_W    = 27;
   localparam int DPROD_W    = 28;
   localparam int SSUM_W     = 29;
   localparam int MAG_W      = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE    = 3'd6;

   localparam logic [11:0]       RST_THRESHOLD  = 12'd41;
   localparam logic [8:0]        RST_CENTER     = 9'd147;
   localparam logic signed [8:0] RST_OFFSET     = 9'sd0;
   localparam logic [15:0]       RST_PROP_GAIN  = 16'd1229;
   localparam logic [15:0]       RST_DERIV_GAIN = 16'd41;
   localparam logic [7:0]        RST_DIVISOR    = 8'd130;
   localparam logic [7:0]        RST_CRUISE     = 8'd179;

   localparam logic signed [ERR_W-1:0]   ERR_MAX   = 10'sd511;
   localparam logic signed [ERR_W-1:0]   ERR_MIN   = -10'sd512;
   localparam logic signed [STEER_W-1:0] STEER_MAX = 16'sh7FFF;
   localparam logic signed [STEER_W-1:0] STEER_MIN = 16'sh8000;
   localparam logic [CENT_W-1:0]         CENT_MAX  = 9'd511;

   typedef struct packed {
      logic pix_take;
      logic cent_load;
      logic div_step;
      logic cent_latch;
      logic prod_en;
      logic steer_load;
      logic out_load;
   } lcps_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic last_pixel;
      logic out_free;
   } lcps_status_type;

endpackage

### sv/lcps_if.sv
interface lcps_req_if;
   logic                            valid;
   logic                            ready;
   logic [lcps_pkg::SAMPLE_W-1:0]   sample;
   logic                            last_pixel;

   modport source (output valid, sample, last_pixel, input ready);
   modport sink   (input valid, sample, last_pixel, output ready);
endinterface

interface lcps_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [lcps_pkg::CENT_W-1:0]            centroid;
   logic                                   line_found;
   logic [lcps_pkg::SPEED_W-1:0]           speed;
   logic signed [lcps_pkg::STEER_W-1:0]    steering;

   modport source (output valid, centroid, line_found, speed, steering, input ready);
   modport sink   (input valid, centroid, line_found, speed, steering, output ready);
endinterface

### sv/lcps_ctrl.sv
module lcps_ctrl #(
   parameter int DIV_STEPS = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lcps_pkg::lcps_status_type status,
   output lcps_pkg::lcps_cmd_type    cmd,
   output logic                      req_ready
);

   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      ST_SCAN,
      ST_CDIV,
      ST_CENT,
      ST_PROD,
      ST_LOAD,
      ST_SDIV,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      step_in   = step_ff;
      case (state_ff)
         ST_SCAN: begin
            req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.pix_take = 1'b1;
               if (status.last_pixel) begin
                  cmd.cent_load = 1'b1;
                  step_in       = LAST_STEP;
                  state_in      = ST_CDIV;
               end
            end
         end
         ST_CDIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_CENT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_CENT: begin
            cmd.cent_latch = 1'b1;
            state_in       = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod_en = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.steer_load = 1'b1;
            step_in        = LAST_STEP;
            state_in       = ST_SDIV;
         end
         ST_SDIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### sv/lcps_dpath.sv
module lcps_dpath #(
   parameter int PIXELS      = 320,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lcps_pkg::lcps_cmd_type                  cmd,
   output lcps_pkg::lcps_status_type               status,
   input  logic                                    req_valid,
   input  logic [lcps_pkg::SAMPLE_W-1:0]           req_sample,
   input  logic                                    req_last_pixel,
   input  logic                                    csr_write_en,
   input  logic [lcps_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [lcps_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output logic [lcps_pkg::CENT_W-1:0]             rsp_centroid,
   output logic                                    rsp_line_found,
   output logic [lcps_pkg::SPEED_W-1:0]            rsp_speed,
   output logic signed [lcps_pkg::STEER_W-1:0]     rsp_steering
);

   localparam int IDX_W = $clog2(PIXELS + 1);
   localparam int SUM_W = $clog2(PIXELS * (PIXELS - 1) / 2 + 1);
   localparam int DW    = (SUM_W > lcps_pkg::MAG_W) ? SUM_W : lcps_pkg::MAG_W;
   localparam int VW    = (IDX_W > 8) ? IDX_W : 8;
   localparam int EW    = ((IDX_W > 9) ? IDX_W : 9) + 3;
   localparam logic [lcps_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      (SAMPLE_BITS >= lcps_pkg::SAMPLE_W) ? {lcps_pkg::SAMPLE_W{1'b1}}
                                          : lcps_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);
   localparam logic [IDX_W-1:0]       PIX_END = IDX_W'(PIXELS);
   localparam logic signed [EW-1:0]   ERR_HI  = EW'(511);
   localparam logic signed [EW-1:0]   ERR_LO  = EW'(-512);
   localparam logic [DW-1:0]          Q_POS   = DW'(32767);
   localparam logic [DW-1:0]          Q_NEG   = DW'(32768);

   // configuration
   logic [11:0]       thr_ff, thr_in;
   logic [8:0]        ctr_ff, ctr_in;
   logic signed [8:0] ofs_ff, ofs_in;
   logic [15:0]       kp_ff, kp_in;
   logic [15:0]       kd_ff, kd_in;
   logic [7:0]        dvs_ff, dvs_in;
   logic [7:0]        crs_ff, crs_in;

   // scan accumulators
   logic [IDX_W-1:0]  idx_ff, idx_in, idx_nx;
   logic [IDX_W-1:0]  cnt_ff, cnt_in, cnt_nx;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_nx;
   logic [lcps_pkg::SAMPLE_W-1:0] sample_m;
   logic              in_range, hit;

   // shared restoring divider
   logic [DW-1:0]     quo_ff, quo_in;
   logic [VW-1:0]     rem_ff, rem_in;
   logic [VW-1:0]     den_ff, den_in;
   logic [VW+1:0]     trial;

   // drive math
   logic [IDX_W-1:0]                            cent_ff, cent_in;
   logic signed [EW-1:0]                        err_full;
   logic signed [lcps_pkg::ERR_W-1:0]           err_ff, err_in;
   logic signed [lcps_pkg::ERR_W-1:0]           prev_ff, prev_in;
   logic signed [lcps_pkg::DERR_W-1:0]          derr_ff, derr_in;
   logic signed [lcps_pkg::PPROD_W-1:0]         pprod_ff, pprod_in;
   logic signed [lcps_pkg::DPROD_W-1:0]         dprod_ff, dprod_in;
   logic signed [lcps_pkg::SSUM_W-1:0]          ssum;
   logic [lcps_pkg::SSUM_W-1:0]                 sneg;
   logic [lcps_pkg::MAG_W-1:0]                  mag;
   logic                                        neg_ff, neg_in;
   logic signed [lcps_pkg::STEER_W-1:0]         steer_val;
   logic [lcps_pkg::CENT_W-1:0]                 cent_sat;

   // result register
   logic                                        ovld_ff, ovld_in;
   logic [lcps_pkg::CENT_W-1:0]                 ocent_ff, ocent_in;
   logic                                        ofound_ff, ofound_in;
   logic [lcps_pkg::SPEED_W-1:0]                ospeed_ff, ospeed_in;
   logic signed [lcps_pkg::STEER_W-1:0]         osteer_ff, osteer_in;

   assign status.req_valid  = req_valid;
   assign status.last_pixel = req_last_pixel;
   assign status.out_free   = !ovld_ff || rsp_ready;

   always_comb begin
      thr_in = thr_ff;
      ctr_in = ctr_ff;
      ofs_in = ofs_ff;
      kp_in  = kp_ff;
      kd_in  = kd_ff;
      dvs_in = dvs_ff;
      crs_in = crs_ff;
      if (csr_write_en) begin
         case (csr_index)
            lcps_pkg::CSR_THRESHOLD:  thr_in = csr_wdata[11:0];
            lcps_pkg::CSR_CENTER:     ctr_in = csr_wdata[8:0];
            lcps_pkg::CSR_OFFSET:     ofs_in = $signed(csr_wdata[8:0]);
            lcps_pkg::CSR_PROP_GAIN:  kp_in  = csr_wdata;
            lcps_pkg::CSR_DERIV_GAIN: kd_in  = csr_wdata;
            lcps_pkg::CSR_DIVISOR:    dvs_in = csr_wdata[7:0];
            lcps_pkg::CSR_CRUISE:     crs_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sample_m = req_sample & SAMPLE_MASK;
      in_range = idx_ff < PIX_END;
      hit      = in_range && (sample_m > thr_ff);
      idx_nx   = idx_ff + IDX_W'(in_range);
      cnt_nx   = cnt_ff + IDX_W'(hit);
      sum_nx   = hit ? (sum_ff + SUM_W'(idx_ff)) : sum_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      if (cmd.pix_take) begin
         if (cmd.cent_load) begin
            idx_in = '0;
            cnt_in = '0;
            sum_in = '0;
         end else begin
            idx_in = idx_nx;
            cnt_in = cnt_nx;
            sum_in = sum_nx;
         end
      end
   end

   always_comb begin
      ssum   = lcps_pkg::SSUM_W'(pprod_ff) + lcps_pkg::SSUM_W'(dprod_ff);
      sneg   = lcps_pkg::SSUM_W'(0) - lcps_pkg::SSUM_W'(ssum);
      mag    = ssum[lcps_pkg::SSUM_W-1] ? sneg[lcps_pkg::MAG_W-1:0]
                                        : ssum[lcps_pkg::MAG_W-1:0];
      trial  = {1'b0, rem_ff, quo_ff[DW-1]} - {2'b00, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      if (cmd.cent_load) begin
         quo_in = DW'(sum_nx);
         rem_in = '0;
         den_in = VW'(cnt_nx);
      end else if (cmd.steer_load) begin
         quo_in = DW'(mag);
         rem_in = '0;
         den_in = (dvs_ff == '0) ? VW'(1) : VW'(dvs_ff);
         neg_in = ssum[lcps_pkg::SSUM_W-1];
      end else if (cmd.div_step) begin
         if (!trial[VW+1]) begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[VW-2:0], quo_ff[DW-1]};
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      cent_in  = cent_ff;
      err_in   = err_ff;
      derr_in  = derr_ff;
      pprod_in = pprod_ff;
      dprod_in = dprod_ff;
      err_full = signed'(EW'(ctr_ff)) - signed'(EW'(quo_ff[IDX_W-1:0])) + EW'(ofs_ff);
      if (cmd.cent_latch) begin
         cent_in = (den_ff == '0) ? '0 : quo_ff[IDX_W-1:0];
         if (err_full > ERR_HI) begin
            err_in = lcps_pkg::ERR_MAX;
         end else if (err_full < ERR_LO) begin
            err_in = lcps_pkg::ERR_MIN;
         end else begin
            err_in = lcps_pkg::ERR_W'(err_full);
         end
         derr_in = lcps_pkg::DERR_W'(err_in) - lcps_pkg::DERR_W'(prev_ff);
      end
      if (cmd.prod_en) begin
         pprod_in = lcps_pkg::PPROD_W'($signed({1'b0, kp_ff}))
                  * lcps_pkg::PPROD_W'(err_ff);
         dprod_in = lcps_pkg::DPROD_W'($signed({1'b0, kd_ff}))
                  * lcps_pkg::DPROD_W'(derr_ff);
      end
   end

   always_comb begin
      if (neg_ff) begin
         steer_val = (quo_ff >= Q_NEG) ? lcps_pkg::STEER_MIN
                                       : $signed(16'(16'd0 - quo_ff[15:0]));
      end else begin
         steer_val = (quo_ff > Q_POS) ? lcps_pkg::STEER_MAX : $signed(quo_ff[15:0]);
      end
      cent_sat  = (cent_ff > lcps_pkg::CENT_MAX) ? lcps_pkg::CENT_MAX
                                                 : lcps_pkg::CENT_W'(cent_ff);
      ovld_in   = ovld_ff;
      ocent_in  = ocent_ff;
      ofound_in = ofound_ff;
      ospeed_in = ospeed_ff;
      osteer_in = osteer_ff;
      prev_in   = prev_ff;
      if (ovld_ff && rsp_ready) begin
         ovld_in = 1'b0;
      end
      if (cmd.out_load) begin
         ovld_in  = 1'b1;
         ocent_in = cent_sat;
         if (cent_ff != '0) begin
            ofound_in = 1'b1;
            ospeed_in = crs_ff;
            osteer_in = steer_val;
            prev_in   = err_ff;
         end else begin
            ofound_in = 1'b0;
            ospeed_in = '0;
            osteer_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= lcps_pkg::RST_THRESHOLD;
         ctr_ff  <= lcps_pkg::RST_CENTER;
         ofs_ff  <= lcps_pkg::RST_OFFSET;
         kp_ff   <= lcps_pkg::RST_PROP_GAIN;
         kd_ff   <= lcps_pkg::RST_DERIV_GAIN;
         dvs_ff  <= lcps_pkg::RST_DIVISOR;
         crs_ff  <= lcps_pkg::RST_CRUISE;
         idx_ff  <= '0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         prev_ff <= '0;
         ovld_ff <= 1'b0;
      end else begin
         thr_ff  <= thr_in;
         ctr_ff  <= ctr_in;
         ofs_ff  <= ofs_in;
         kp_ff   <= kp_in;
         kd_ff   <= kd_in;
         dvs_ff  <= dvs_in;
         crs_ff  <= crs_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         prev_ff <= prev_in;
         ovld_ff <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      cent_ff   <= cent_in;
      err_ff    <= err_in;
      derr_ff   <= derr_in;
      pprod_ff  <= pprod_in;
      dprod_ff  <= dprod_in;
      ocent_ff  <= ocent_in;
      ofound_ff <= ofound_in;
      ospeed_ff <= ospeed_in;
      osteer_ff <= osteer_in;
   end

   assign rsp_valid      = ovld_ff;
   assign rsp_centroid   = ocent_ff;
   assign rsp_line_found = ofound_ff;
   assign rsp_speed      = ospeed_ff;
   assign rsp_steering   = osteer_ff;

endmodule

### sv/line_centroid_pd_steering_top.sv
// Channel   Dir  Payload                                   Transfer
// req_chan  in   sample[11:0], last_pixel                  valid & ready
// rsp_chan  out  centroid[8:0], line_found, speed[7:0],    valid & ready
//                steering[15:0] (signed)
// csr_*     in   csr_index[2:0], csr_wdata[15:0]           csr_write_en
//
// Pixels transfer one per cycle while a scan is in progress.
// After the last pixel the block is busy with the centroid division, the error,
// the PD products and the steering division: both divisions run one quotient bit
// per cycle on one shared restoring divider, DIV_STEPS = 28 steps each.
// Reset is synchronous and restores the register defaults and clears state.
// A stalled result holds in the output register; a finished result waits in the
// done state until the output register is free, and only then is the next scan taken.
module line_centroid_pd_steering_top #(
   parameter int PIXELS      = 320,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   lcps_req_if.sink                            req_chan,
   lcps_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [lcps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SUM_W     = $clog2(PIXELS * (PIXELS - 1) / 2 + 1);
   localparam int DIV_STEPS = (SUM_W > lcps_pkg::MAG_W) ? SUM_W : lcps_pkg::MAG_W;

   lcps_pkg::lcps_cmd_type    cmd;
   lcps_pkg::lcps_status_type status;
   logic                      ctl_ready;

   assign req_chan.ready = ctl_ready;

   lcps_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (ctl_ready)
   );

   lcps_dpath #(
      .PIXELS      (PIXELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_valid      (req_chan.valid),
      .req_sample     (req_chan.sample),
      .req_last_pixel (req_chan.last_pixel),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_centroid   (rsp_chan.centroid),
      .rsp_line_found (rsp_chan.line_found),
      .rsp_speed      (rsp_chan.speed),
      .rsp_steering   (rsp_chan.steering)
   );

endmodule

### sv/lcps_checker.sv
module lcps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_last_pixel,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [lcps_pkg::CENT_W-1:0]         rsp_centroid,
   input logic                                rsp_line_found,
   input logic [lcps_pkg::SPEED_W-1:0]        rsp_speed,
   input logic signed [lcps_pkg::STEER_W-1:0] rsp_steering
);

   // end of scan takes the block busy
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_pixel |=> !req_ready)
      else $error("input ready after last pixel transfer");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while scanning");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_found |-> rsp_speed == '0 && rsp_steering == '0)
      else $error("drive commanded without line");

   a_found_centroid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_found == (rsp_centroid != '0))
      else $error("line_found disagrees with centroid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_centroid)
                                  && $stable(rsp_steering))
      else $error("stalled result changed");

endmodule

bind line_centroid_pd_steering_top lcps_checker u_lcps_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last_pixel (req_chan.last_pixel),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_centroid   (rsp_chan.centroid),
   .rsp_line_found (rsp_chan.line_found),
   .rsp_speed      (rsp_chan.speed),
   .rsp_steering   (rsp_chan.steering)
);

### test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCAN_PIXELS    = 320;
   localparam int STALL_PCT      = 15;
   localparam int DRAIN_CYCLES   = 70;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [lcps_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [lcps_pkg::CENT_W-1:0]         centroid;
      logic                                line_found;
      logic [lcps_pkg::SPEED_W-1:0]        speed;
      logic signed [lcps_pkg::STEER_W-1:0] steering;
   } drive_cmd_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_en;
   logic [lcps_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lcps_pkg::CSR_DATA_W-1:0] csr_wdata;

   lcps_req_if req_chan ();
   lcps_rsp_if rsp_chan ();

   line_centroid_pd_steering_top #(
      .PIXELS      (SCAN_PIXELS),
      .SAMPLE_BITS (lcps_pkg::SAMPLE_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // register image
   logic [lcps_pkg::SAMPLE_W-1:0]      cfg_threshold;
   logic [lcps_pkg::CENT_W-1:0]        cfg_center;
   logic signed [lcps_pkg::CENT_W-1:0] cfg_offset;
   logic [15:0]                        cfg_prop_gain;
   logic [15:0]                        cfg_deriv_gain;
   logic [7:0]                         cfg_divisor;
   logic [lcps_pkg::SPEED_W-1:0]       cfg_cruise;

   // scan accumulation and PD history
   int unsigned scan_index;
   int unsigned line_hits;
   int unsigned index_total;
   longint      held_error;

   drive_cmd_type pending_drive_cmds[$];

   bit calm = 1'b0;
   int mismatches = 0;
   int pixels_sent = 0;
   int scans_done = 0;
   int drives_checked = 0;
   int stops_checked = 0;
   int idle_cycles = 0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void predictor_reset();
      cfg_threshold  = lcps_pkg::RST_THRESHOLD;
      cfg_center     = lcps_pkg::RST_CENTER;
      cfg_offset     = lcps_pkg::RST_OFFSET;
      cfg_prop_gain  = lcps_pkg::RST_PROP_GAIN;
      cfg_deriv_gain = lcps_pkg::RST_DERIV_GAIN;
      cfg_divisor    = lcps_pkg::RST_DIVISOR;
      cfg_cruise     = lcps_pkg::RST_CRUISE;
      scan_index     = 0;
      line_hits      = 0;
      index_total    = 0;
      held_error     = 0;
   endfunction

   function automatic void take_pixel(logic [lcps_pkg::SAMPLE_W-1:0] s, logic last);
      drive_cmd_type cmd;
      int unsigned   cent;
      longint        err;
      longint        acc;
      longint        divisor_v;
      longint        quot;
      if (scan_index < SCAN_PIXELS) begin
         if (s > cfg_threshold) begin
            line_hits++;
            index_total += scan_index;
         end
         scan_index++;
      end
      if (!last) return;
      cent = (line_hits != 0) ? index_total / line_hits : 0;
      cmd = '0;
      cmd.centroid = (cent > 32'(lcps_pkg::CENT_MAX)) ? lcps_pkg::CENT_MAX
                                                      : cent[lcps_pkg::CENT_W-1:0];
      if (cent != 0) begin
         err = clamp(longint'(cfg_center) - longint'(cent) + longint'(cfg_offset),
                     longint'(lcps_pkg::ERR_MIN), longint'(lcps_pkg::ERR_MAX));
         acc = longint'(cfg_prop_gain) * err + longint'(cfg_deriv_gain) * (err - held_error);
         divisor_v = (cfg_divisor == 0) ? 64'sd1 : longint'(cfg_divisor);
         quot = clamp(acc / divisor_v, longint'(lcps_pkg::STEER_MIN),
                      longint'(lcps_pkg::STEER_MAX));
         held_error = err;
         cmd.line_found = 1'b1;
         cmd.speed = cfg_cruise;
         cmd.steering = quot[lcps_pkg::STEER_W-1:0];
      end
      pending_drive_cmds.push_back(cmd);
      scans_done++;
      scan_index = 0;
      line_hits = 0;
      index_total = 0;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic write_reg(input logic [lcps_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lcps_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         lcps_pkg::CSR_THRESHOLD:  cfg_threshold = data[lcps_pkg::SAMPLE_W-1:0];
         lcps_pkg::CSR_CENTER:     cfg_center = data[lcps_pkg::CENT_W-1:0];
         lcps_pkg::CSR_OFFSET:     cfg_offset = signed'(data[lcps_pkg::CENT_W-1:0]);
         lcps_pkg::CSR_PROP_GAIN:  cfg_prop_gain = data[15:0];
         lcps_pkg::CSR_DERIV_GAIN: cfg_deriv_gain = data[15:0];
         lcps_pkg::CSR_DIVISOR:    cfg_divisor = data[7:0];
         lcps_pkg::CSR_CRUISE:     cfg_cruise = data[lcps_pkg::SPEED_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [lcps_pkg::SAMPLE_W-1:0] thr,
                             input logic [lcps_pkg::CENT_W-1:0] center,
                             input logic [lcps_pkg::CENT_W-1:0] offset, input logic [15:0] kp,
                             input logic [15:0] kd, input logic [7:0] divisor,
                             input logic [lcps_pkg::SPEED_W-1:0] cruise);
      write_reg(lcps_pkg::CSR_THRESHOLD, lcps_pkg::CSR_DATA_W'(thr));
      write_reg(lcps_pkg::CSR_CENTER, lcps_pkg::CSR_DATA_W'(center));
      write_reg(lcps_pkg::CSR_OFFSET, lcps_pkg::CSR_DATA_W'(offset));
      write_reg(lcps_pkg::CSR_PROP_GAIN, kp);
      write_reg(lcps_pkg::CSR_DERIV_GAIN, kd);
      write_reg(lcps_pkg::CSR_DIVISOR, lcps_pkg::CSR_DATA_W'(divisor));
      write_reg(lcps_pkg::CSR_CRUISE, lcps_pkg::CSR_DATA_W'(cruise));
   endtask

   task automatic send_pixel(input logic [lcps_pkg::SAMPLE_W-1:0] s, input logic last);
      if (!calm) begin
         while ($urandom_range(99) < STALL_PCT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= s;
      req_chan.last_pixel <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      take_pixel(s, last);
      pixels_sent++;
   endtask

   // band [lo, hi] is line, the rest background, with some noise pixels
   task automatic send_scan(input int len, input int lo, input int hi, input bit no_line);
      logic [lcps_pkg::SAMPLE_W-1:0] s;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0)
            s = lcps_pkg::SAMPLE_W'($urandom_range(0, 4095));
         else if (!no_line && i >= lo && i <= hi)
            s = (cfg_threshold == 12'hFFF) ? 12'hFFF
                : lcps_pkg::SAMPLE_W'($urandom_range(cfg_threshold + 1, 4095));
         else
            s = lcps_pkg::SAMPLE_W'($urandom_range(0, cfg_threshold));
         send_pixel(s, i == len - 1);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_drive_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // threshold is strict, empty scan, mean truncating to zero, held error
   task automatic test_scan_basics();
      send_pixel(12'd41, 1'b0);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'hFFF, 1'b1);
      send_pixel(12'hFFF, 1'b1);
      send_pixel(12'd0, 1'b1);
      send_pixel(12'd42, 1'b0);
      send_pixel(12'd42, 1'b1);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd42, 1'b1);
      drain();
   endtask

   // error and steering saturation, divisor zero, unmapped index, threshold max
   task automatic test_gain_extremes();
      set_config(12'd0, 9'd511, 9'd255, 16'hFFFF, 16'hFFFF, 8'd0, 8'd255);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd1, 1'b1);
      drain();
      set_config(12'd4094, 9'd0, 9'h100, 16'd0, 16'hFFFF, 8'd255, 8'd0);
      write_reg(CSR_UNMAPPED, 16'h0001);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'd0, 1'b0);
      send_pixel(12'hFFF, 1'b1);
      send_pixel(12'd4094, 1'b1);
      drain();
      write_reg(lcps_pkg::CSR_THRESHOLD, 16'h0FFF);
      send_pixel(12'hFFF, 1'b1);
      drain();
   endtask

   // pixels past the end are dropped; then one exact full-length scan
   task automatic test_scan_overrun();
      int lo;
      set_config(12'd2048, 9'd0, 9'h100, 16'd1229, 16'd41, 8'd1, 8'd100);
      for (int i = 0; i < SCAN_PIXELS + 20; i++)
         send_pixel((i >= 300) ? lcps_pkg::SAMPLE_W'($urandom_range(2049, 4095))
                               : lcps_pkg::SAMPLE_W'($urandom_range(0, 2048)),
                    i == SCAN_PIXELS + 19);
      drain();
      set_config(lcps_pkg::RST_THRESHOLD, lcps_pkg::RST_CENTER, lcps_pkg::RST_OFFSET,
                 lcps_pkg::RST_PROP_GAIN, lcps_pkg::RST_DERIV_GAIN,
                 lcps_pkg::RST_DIVISOR, lcps_pkg::RST_CRUISE);
      lo = $urandom_range(0, SCAN_PIXELS - 1);
      send_scan(SCAN_PIXELS, lo, $urandom_range(lo, SCAN_PIXELS - 1), 1'b0);
      drain();
   endtask

   task automatic test_random_scans();
      int len;
      int lo;
      int sent;
      logic [7:0] divisor;
      for (int phase = 0; phase < 4; phase++) begin
         calm = (phase == 2);
         case (phase)
            0: divisor = 8'd1;
            1: divisor = 8'($urandom_range(0, 255));
            2: divisor = 8'd255;
            default: divisor = 8'($urandom_range(1, 255));
         endcase
         set_config(lcps_pkg::SAMPLE_W'($urandom_range(0, 3900)),
                    lcps_pkg::CENT_W'($urandom_range(0, 511)),
                    lcps_pkg::CENT_W'($urandom_range(0, 511)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), divisor,
                    lcps_pkg::SPEED_W'($urandom_range(0, 255)));
         sent = 0;
         while (sent < 145) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            lo = $urandom_range(0, len - 1);
            send_scan(len, lo, $urandom_range(lo, len - 1), $urandom_range(7) == 0);
            sent += len;
         end
         drain();
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= STALL_PCT);
   end

   always @(posedge clock) begin : check_result
      drive_cmd_type got;
      drive_cmd_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.centroid = rsp_chan.centroid;
         got.line_found = rsp_chan.line_found;
         got.speed = rsp_chan.speed;
         got.steering = rsp_chan.steering;
         if (pending_drive_cmds.size() == 0) begin
            report_mismatch($sformatf("result with none pending, centroid %0d", got.centroid));
         end else begin
            want = pending_drive_cmds.pop_front();
            if (want.line_found) drives_checked++;
            else stops_checked++;
            if (got.centroid !== want.centroid)
               report_mismatch($sformatf("centroid %0d, want %0d", got.centroid, want.centroid));
            if (got.line_found !== want.line_found)
               report_mismatch($sformatf("line_found %0b, want %0b",
                                         got.line_found, want.line_found));
            if (got.speed !== want.speed)
               report_mismatch($sformatf("speed %0d, want %0d", got.speed, want.speed));
            if (got.steering !== want.steering)
               report_mismatch($sformatf("steering %0d, want %0d",
                                         $signed(got.steering), $signed(want.steering)));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      req_chan.last_pixel = 1'b0;
      rsp_chan.ready = 1'b0;
      predictor_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_scan_basics();
      test_gain_extremes();
      test_scan_overrun();
      test_random_scans();
      $display("%0d pixels in %0d scans over several register settings", pixels_sent, scans_done);
      $display("%0d drive and %0d stop results checked, %0d mismatches",
               drives_checked, stops_checked, mismatches);
      if (mismatches == 0 && pending_drive_cmds.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
